### rtl/sfma_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_pkg: shared types and constants for the spectrum frame moving average
// Sizes of the history ring, field widths, sequencer states and bin count.
// ----------------------------------------------------------------------------
package sfma_pkg;

  localparam int FRAMES    = 8;      // frames kept per bin
  localparam int MAX_BINS  = 128;    // bins per frame at most
  localparam int BASE_BINS = 128;    // bins per frame at shift zero

  localparam int RSSI_W  = 16;
  localparam int SHIFT_W = 2;
  localparam int PREV_W  = SHIFT_W + 1;

  localparam logic [RSSI_W-1:0] FULL_SCALE = {RSSI_W{1'b1}};
  localparam logic [PREV_W-1:0] PREV_NONE  = PREV_W'(4);   // no frame seen yet
  localparam logic [SHIFT_W-1:0] SHIFT_RESET = SHIFT_W'(1);

  localparam int SLOT_W = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int BIN_W  = $clog2(MAX_BINS);
  localparam int CNT_W  = $clog2(MAX_BINS + 1);
  localparam int PH_W   = $clog2(FRAMES + 1);
  localparam int SUM_W  = RSSI_W + $clog2(FRAMES);
  localparam int MSUM_W = RSSI_W + $clog2(MAX_BINS);
  localparam int DEPTH  = FRAMES * MAX_BINS;
  localparam int ADDR_W = $clog2(DEPTH);
  localparam int BASE_W = $clog2(BASE_BINS + 1);
  localparam int FB_W   = (BASE_W > CNT_W) ? BASE_W : CNT_W;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_ACCUM,
    ST_STAT,
    ST_DIV_GO,
    ST_DIV_WAIT,
    ST_FINISH
  } seq_state_t;

  // bins per frame for a given shift, saturated to MAX_BINS
  function automatic logic [CNT_W-1:0] frame_bins(input logic [SHIFT_W-1:0] sh);
    logic [FB_W-1:0] base;
    base = FB_W'(BASE_BINS) >> sh;
    if (base > FB_W'(MAX_BINS)) begin
      base = FB_W'(MAX_BINS);
    end
    return CNT_W'(base);
  endfunction

endpackage

### rtl/sfma_div.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_div: radix-2 restoring divider
// One quotient bit per cycle; done pulses with the quotient valid.
// ----------------------------------------------------------------------------
module sfma_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [sfma_pkg::MSUM_W-1:0]   dividend,
  input  logic [sfma_pkg::CNT_W-1:0]    divisor,
  output logic                          done,
  output logic [sfma_pkg::MSUM_W-1:0]   quotient
);
  import sfma_pkg::*;

  localparam int ITER_W = $clog2(MSUM_W + 1);

  logic [ITER_W-1:0] iter;
  logic [CNT_W-1:0]  rem;
  logic [CNT_W:0]    trial;
  logic              fits;

  assign trial = {rem, quotient[MSUM_W-1]};
  assign fits  = (trial >= {1'b0, divisor});

  always_ff @(posedge clk) begin
    if (rst) begin
      iter <= '0;
      done <= 1'b0;
    end else begin
      done <= 1'b0;
      if (start) begin
        iter     <= ITER_W'(MSUM_W);
        rem      <= '0;
        quotient <= dividend;
      end else if (iter != '0) begin
        iter     <= iter - ITER_W'(1);
        done     <= (iter == ITER_W'(1));
        rem      <= fits ? CNT_W'(trial - {1'b0, divisor}) : CNT_W'(trial);
        quotient <= {quotient[MSUM_W-2:0], fits};
      end
    end
  end

endmodule

### rtl/spectrum_frame_moving_average_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spectrum_frame_moving_average_core: per-bin moving average over frames
// Keeps the last FRAMES frames of every bin in a ring and reports each bin's
// floor mean, plus min, max and mean of the kept bin means at frame end.
// ----------------------------------------------------------------------------
// Path: a beat passes ST_ACCUM (sweep of every slot), ST_STAT and ST_FINISH
//   (result load); the last bin of a frame with a kept bin adds ST_DIV_GO and
//   ST_DIV_WAIT for the mean-of-means divide. Flow: one bin at a time, set by
//   the single history RAM port visiting every slot of the bin once; in_stall
//   is high meanwhile and a stalled result holds the sequencer in its last step.
// Reset: synchronous, active high; clears ring pointer, bin counter and frame
//   statistics, bins_shift returns to 1. The history RAM is not cleared: the
//   first frame after reset always refills every slot of each of its bins.
// ----------------------------------------------------------------------------
module spectrum_frame_moving_average_core (
  input  logic                          clk,
  input  logic                          rst,
  // configuration: bins_shift
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [sfma_pkg::SHIFT_W-1:0]  cfg_data,
  // input beats
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [sfma_pkg::RSSI_W-1:0]   rssi,
  input  logic                          skip,
  input  logic                          fill,
  // result beats
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [sfma_pkg::RSSI_W-1:0]   bin_mean,
  output logic                          bin_skipped,
  output logic                          frame_done,
  output logic [sfma_pkg::RSSI_W-1:0]   frame_min,
  output logic [sfma_pkg::RSSI_W-1:0]   frame_max,
  output logic [sfma_pkg::RSSI_W-1:0]   frame_mid,
  output logic                          all_skipped
);
  import sfma_pkg::*;

  // sequencer
  seq_state_t state, state_next;

  // configuration and per-frame control
  logic [SHIFT_W-1:0] bins_shift;
  logic [PREV_W-1:0]  prev_bins_shift;
  logic [SLOT_W-1:0]  newest_slot;
  logic [BIN_W-1:0]   bin_index;
  logic               refill_frame;

  // current bin
  logic [RSSI_W-1:0]  rssi_q;
  logic               skip_q;
  logic [RSSI_W-1:0]  mean_q;

  // slot sweep
  logic [PH_W-1:0]    phase;
  logic               rd_pend;
  logic               use_rssi_d;
  logic [SUM_W-1:0]   acc_sum;

  // frame statistics
  logic [RSSI_W-1:0]  run_min;
  logic [RSSI_W-1:0]  run_max;
  logic [MSUM_W-1:0]  mean_sum;
  logic [CNT_W-1:0]   kept_count;
  logic [RSSI_W-1:0]  held_mid;

  // history RAM
  logic [RSSI_W-1:0]  history [DEPTH];
  logic [RSSI_W-1:0]  rdata;
  logic [ADDR_W-1:0]  addr;
  logic               mem_we;

  // combinational helpers
  logic               in_accept;
  logic               sweeping;
  logic [SLOT_W-1:0]  slot;
  logic               slot_new;
  logic [CNT_W-1:0]   n_bins;
  logic               frame_last;
  logic               kept_nz;
  logic [RSSI_W-1:0]  mean_w;
  logic               div_start;
  logic               div_done;
  logic [MSUM_W-1:0]  div_quo;
  logic               load_out;

  assign cfg_ready  = 1'b1;
  assign in_accept  = in_valid && !in_stall;
  assign sweeping   = (state == ST_ACCUM) && (phase < PH_W'(FRAMES));
  assign slot       = phase[SLOT_W-1:0];
  assign slot_new   = refill_frame || (slot == newest_slot);
  assign n_bins     = frame_bins(prev_bins_shift[SHIFT_W-1:0]);
  assign frame_last = (CNT_W'(bin_index) + CNT_W'(1)) >= n_bins;
  assign kept_nz    = (kept_count != '0) || !skip_q;
  assign mean_w     = RSSI_W'(acc_sum / FRAMES);
  assign addr       = ADDR_W'(ADDR_W'(slot) * ADDR_W'(MAX_BINS)) + ADDR_W'(bin_index);

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (in_accept) state_next = ST_ACCUM;
      end
      ST_ACCUM: begin
        if (phase == PH_W'(FRAMES)) state_next = ST_STAT;
      end
      ST_STAT: begin
        state_next = (frame_last && kept_nz) ? ST_DIV_GO : ST_FINISH;
      end
      ST_DIV_GO: begin
        state_next = ST_DIV_WAIT;
      end
      ST_DIV_WAIT: begin
        if (div_done) state_next = ST_FINISH;
      end
      ST_FINISH: begin
        if (!out_valid || !out_stall) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    in_stall  = (state != ST_IDLE);
    mem_we    = sweeping && slot_new;
    div_start = (state == ST_DIV_GO);
    load_out  = (state == ST_FINISH) && (!out_valid || !out_stall);
  end

  // one write and one registered read per cycle
  always_ff @(posedge clk) begin
    if (mem_we) begin
      history[addr] <= rssi_q;
    end
    rdata <= history[addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= ST_IDLE;
      bins_shift      <= SHIFT_RESET;
      prev_bins_shift <= PREV_NONE;
      newest_slot     <= '0;
      bin_index       <= '0;
      refill_frame    <= 1'b0;
      phase           <= '0;
      rd_pend         <= 1'b0;
      run_min         <= FULL_SCALE;
      run_max         <= '0;
      mean_sum        <= '0;
      kept_count      <= '0;
      held_mid        <= '0;
      out_valid       <= 1'b0;
    end else begin
      state <= state_next;

      if (cfg_valid && cfg_ready) begin
        bins_shift <= cfg_data;
      end

      // take the beat; frame start latches the shift and advances the ring
      if (in_accept) begin
        rssi_q  <= rssi;
        skip_q  <= skip;
        phase   <= '0;
        rd_pend <= 1'b0;
        acc_sum <= '0;
        if (bin_index == '0) begin
          refill_frame    <= fill || ({1'b0, bins_shift} != prev_bins_shift);
          prev_bins_shift <= {1'b0, bins_shift};
          newest_slot     <= (newest_slot == SLOT_W'(FRAMES - 1)) ? '0
                                                                : newest_slot + SLOT_W'(1);
        end
      end

      // sweep all slots: freshly written slots contribute the new sample
      if (state == ST_ACCUM) begin
        phase      <= phase + PH_W'(1);
        rd_pend    <= sweeping;
        use_rssi_d <= slot_new;
        if (rd_pend) begin
          acc_sum <= acc_sum + SUM_W'(use_rssi_d ? rssi_q : rdata);
        end
      end

      if (state == ST_STAT) begin
        mean_q <= mean_w;
        if (!skip_q) begin
          mean_sum   <= mean_sum + MSUM_W'(mean_w);
          kept_count <= kept_count + CNT_W'(1);
          if (mean_w > run_max) run_max <= mean_w;
          if (mean_w < run_min) run_min <= mean_w;
        end
      end

      if ((state == ST_DIV_WAIT) && div_done) begin
        held_mid <= div_quo[RSSI_W-1:0];
      end

      if (load_out) begin
        out_valid <= 1'b1;
        if (frame_last) begin
          run_min    <= FULL_SCALE;
          run_max    <= '0;
          mean_sum   <= '0;
          kept_count <= '0;
          bin_index  <= '0;
        end else begin
          bin_index  <= bin_index + BIN_W'(1);
        end
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // result register; frame fields read zero off the last bin
  always_ff @(posedge clk) begin
    if (load_out) begin
      bin_mean    <= skip_q ? '0 : mean_q;
      bin_skipped <= skip_q;
      frame_done  <= frame_last;
      frame_min   <= frame_last ? run_min : '0;
      frame_max   <= frame_last ? run_max : '0;
      frame_mid   <= frame_last ? held_mid : '0;
      all_skipped <= frame_last && (kept_count == '0);
    end
  end

  sfma_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (mean_sum),
    .divisor  (kept_count),
    .done     (div_done),
    .quotient (div_quo)
  );

endmodule

### rtl/sfma_check.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sfma_check: port-level checks for the spectrum frame moving average
// Watches the result channel and the relations among frame statistics.
// ----------------------------------------------------------------------------
module sfma_check (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          out_valid,
  input  logic                          out_stall,
  input  logic [sfma_pkg::RSSI_W-1:0]   bin_mean,
  input  logic                          bin_skipped,
  input  logic                          frame_done,
  input  logic [sfma_pkg::RSSI_W-1:0]   frame_min,
  input  logic [sfma_pkg::RSSI_W-1:0]   frame_max,
  input  logic [sfma_pkg::RSSI_W-1:0]   frame_mid,
  input  logic                          all_skipped
);
  import sfma_pkg::*;

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(bin_mean) && $stable(frame_mid))
    else $error("result beat changed while stalled");

  a_skip_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && bin_skipped |-> bin_mean == '0)
    else $error("skipped bin carries a mean");

  a_mid_bin: assert property (@(posedge clk) disable iff (rst)
    out_valid && !frame_done |->
      frame_min == '0 && frame_max == '0 && frame_mid == '0 && !all_skipped)
    else $error("frame statistics off the last bin");

  a_all_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done && all_skipped |->
      frame_min == FULL_SCALE && frame_max == '0 && bin_skipped)
    else $error("empty frame statistics wrong");

  a_order: assert property (@(posedge clk) disable iff (rst)
    out_valid && frame_done && !all_skipped |->
      frame_min <= frame_mid && frame_mid <= frame_max)
    else $error("frame min, mid, max out of order");

endmodule

bind spectrum_frame_moving_average_core sfma_check u_sfma_check (.*);

### tb/tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb: self-checking bench for spectrum_frame_moving_average_core
// Bins go in through a bursty driver and results come out through a monitor.
// The monitor checks each result beat against an in-bench per-bin average
// model. bins_shift is rewritten between phases, sometimes mid-frame. The
// receiver stalls in shifting patterns, with long hold-offs that back the
// block up into its input.
// ----------------------------------------------------------------------------
module tb;
  import sfma_pkg::*;

  typedef struct packed {
    logic [RSSI_W-1:0] rssi;
    logic              skip;
    logic              fill;
  } bin_sample_t;

  typedef struct packed {
    logic [RSSI_W-1:0] bin_mean;
    logic              bin_skipped;
    logic              frame_done;
    logic [RSSI_W-1:0] frame_min;
    logic [RSSI_W-1:0] frame_max;
    logic [RSSI_W-1:0] frame_mid;
    logic              all_skipped;
  } avg_beat_t;

  logic               clk;
  logic               rst = 1'b1;
  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [SHIFT_W-1:0] cfg_data = '0;
  logic               in_valid = 1'b0;
  logic               in_stall;
  logic [RSSI_W-1:0]  rssi = '0;
  logic               skip = 1'b0;
  logic               fill = 1'b0;
  logic               out_valid;
  logic               out_stall = 1'b0;
  logic [RSSI_W-1:0]  bin_mean;
  logic               bin_skipped;
  logic               frame_done;
  logic [RSSI_W-1:0]  frame_min;
  logic [RSSI_W-1:0]  frame_max;
  logic [RSSI_W-1:0]  frame_mid;
  logic               all_skipped;

  spectrum_frame_moving_average_core dut (
    .clk         (clk),
    .rst         (rst),
    .cfg_valid   (cfg_valid),
    .cfg_ready   (cfg_ready),
    .cfg_data    (cfg_data),
    .in_valid    (in_valid),
    .in_stall    (in_stall),
    .rssi        (rssi),
    .skip        (skip),
    .fill        (fill),
    .out_valid   (out_valid),
    .out_stall   (out_stall),
    .bin_mean    (bin_mean),
    .bin_skipped (bin_skipped),
    .frame_done  (frame_done),
    .frame_min   (frame_min),
    .frame_max   (frame_max),
    .frame_mid   (frame_mid),
    .all_skipped (all_skipped)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // Hard stop, far beyond the slowest legal run.
  initial begin
    #4_000_000;
    $display("TB_ERROR");
    $finish;
  end

  bin_sample_t sample_q[$];   // bins waiting for the driver
  avg_beat_t   due_avgs[$];   // predicted result beats, oldest first
  int unsigned errors = 0;
  int unsigned in_beats = 0;

  // ---------------------------------------------------------------------------
  // Per-bin average model
  // ---------------------------------------------------------------------------
  logic [RSSI_W-1:0] hist [0:FRAMES*MAX_BINS-1];
  int unsigned slot_now = 0;
  int unsigned bin_now = 0;
  int unsigned shift_seen = 4;    // 4: no frame started yet, forces a refill
  int unsigned shift_cfg = 1;
  int unsigned run_lo = 65535;
  int unsigned run_hi = 0;
  int unsigned kept_sum = 0;
  int unsigned kept_n = 0;
  int unsigned mid_held = 0;
  bit          refill_now = 1'b0;

  function automatic int unsigned bins_for(input int unsigned sh);
    int unsigned nb;
    nb = BASE_BINS >> (sh & 3);
    if (nb > MAX_BINS) nb = MAX_BINS;
    return nb;
  endfunction

  task automatic advance_average(input logic [RSSI_W-1:0] r, input logic sk,
                                 input logic fl);
    int unsigned nb, b, s, sum, mean;
    avg_beat_t   e;
    if (bin_now == 0) begin
      refill_now = fl || (shift_cfg != shift_seen);
      shift_seen = shift_cfg;
      slot_now   = (slot_now + 1) % FRAMES;
    end
    nb = bins_for(shift_seen);
    b  = (bin_now >= nb) ? nb - 1 : bin_now;
    if (refill_now) begin
      for (s = 0; s < FRAMES; s++) hist[s*MAX_BINS + b] = r;
    end else begin
      hist[slot_now*MAX_BINS + b] = r;
    end
    sum = 0;
    for (s = 0; s < FRAMES; s++) sum += hist[s*MAX_BINS + b];
    mean = sum / FRAMES;
    if (!sk) begin
      kept_sum += mean;
      kept_n++;
      if (mean > run_hi) run_hi = mean;
      if (mean < run_lo) run_lo = mean;
    end
    e             = '0;
    e.bin_mean    = sk ? '0 : mean[RSSI_W-1:0];
    e.bin_skipped = sk;
    e.frame_done  = (b + 1 >= nb);
    if (e.frame_done) begin
      if (kept_n != 0) mid_held = (kept_sum / kept_n) & 16'hFFFF;
      e.frame_min   = run_lo[RSSI_W-1:0];
      e.frame_max   = run_hi[RSSI_W-1:0];
      e.frame_mid   = mid_held[RSSI_W-1:0];
      e.all_skipped = (kept_n == 0);
      run_lo   = 65535;
      run_hi   = 0;
      kept_sum = 0;
      kept_n   = 0;
      bin_now  = 0;
    end else begin
      bin_now = b + 1;
    end
    due_avgs.push_back(e);
  endtask

  // ---------------------------------------------------------------------------
  // Driver: bursts of beats with random gaps; payload holds while stalled
  // ---------------------------------------------------------------------------
  int unsigned gap_left = 0;
  int unsigned burst_left = 0;

  always @(posedge clk) begin : driver
    bin_sample_t cur;
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        advance_average(rssi, skip, fill);
        in_beats <= in_beats + 1;
      end
      if (!(in_valid && in_stall)) begin
        if (gap_left != 0) begin
          gap_left--;
          in_valid <= 1'b0;
        end else if (sample_q.size() != 0) begin
          cur = sample_q.pop_front();
          in_valid <= 1'b1;
          rssi     <= cur.rssi;
          skip     <= cur.skip;
          fill     <= cur.fill;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(1, 40);
            gap_left   = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
          end else begin
            burst_left--;
          end
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Receiver stall: stall_tick sets when the pattern is redrawn; a long hold-off every
  // 350 input beats lets the block back up and stall its input.
  // ---------------------------------------------------------------------------
  int unsigned stall_tick = 0;
  int unsigned stall_mode = 0;
  int unsigned hold_left = 0;
  int unsigned next_hold = 100;

  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      stall_tick++;
      if (stall_tick % 200 == 0) stall_mode = $urandom_range(0, 3);
      if (hold_left == 0 && in_beats >= next_hold) begin
        hold_left = $urandom_range(150, 300);
        next_hold += 350;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_stall <= 1'b1;
      end else begin
        case (stall_mode)
          0: out_stall <= 1'b0;
          1: out_stall <= ($urandom_range(0, 3) == 0);
          2: out_stall <= ($urandom_range(0, 3) != 0);
          default: out_stall <= (stall_tick % 3 != 0);
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Monitor: every accepted result beat against the oldest prediction
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin : monitor
    avg_beat_t want, got;
    if (!rst && out_valid && !out_stall) begin
      got = '{bin_mean, bin_skipped, frame_done, frame_min, frame_max,
              frame_mid, all_skipped};
      if (due_avgs.size() == 0) begin
        errors++;
        if (errors < 30)
          $display("%0t: unexpected result beat mean=%0d done=%0b", $time,
                   got.bin_mean, got.frame_done);
      end else begin
        want = due_avgs.pop_front();
        if (got !== want) begin
          errors++;
          if (errors < 30) begin
            $display("%0t: mismatch expected mean=%0d skp=%0b done=%0b min=%0d max=%0d",
                     $time, want.bin_mean, want.bin_skipped, want.frame_done,
                     want.frame_min, want.frame_max);
            $display("    expected mid=%0d all=%0b | actual mean=%0d skp=%0b done=%0b",
                     want.frame_mid, want.all_skipped, got.bin_mean,
                     got.bin_skipped, got.frame_done);
            $display("    actual min=%0d max=%0d mid=%0d all=%0b", got.frame_min,
                     got.frame_max, got.frame_mid, got.all_skipped);
          end
        end
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  task automatic push_sample(input logic [RSSI_W-1:0] r, input logic sk,
                             input logic fl);
    bin_sample_t t;
    t.rssi = r;
    t.skip = sk;
    t.fill = fl;
    sample_q.push_back(t);
  endtask

  // Register writes only happen with nothing in flight.
  task automatic write_shift(input int unsigned v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data  <= v[SHIFT_W-1:0];
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    shift_cfg = v & 3;
  endtask

  task automatic drain();
    while (sample_q.size() != 0 || in_valid || due_avgs.size() != 0)
      @(posedge clk);
  endtask

  // Bins of random content, frame by frame; the phase may stop mid-frame.
  task automatic queue_frames(input int unsigned count, input int unsigned sh);
    int unsigned left, pos, len, style, skip_mode, lvl, k;
    logic [RSSI_W-1:0] r;
    logic sk;
    left = count;
    pos  = bin_now;
    while (left > 0) begin
      len       = (pos == 0) ? bins_for(sh) : bins_for(shift_seen);
      style     = $urandom_range(0, 3);
      skip_mode = $urandom_range(0, 9);
      lvl       = $urandom_range(0, 65535);
      while (pos < len && left > 0) begin
        k = $urandom;
        case (style)
          0: r = k[15:0];
          1: r = k[3:0];
          2: r = 16'hFFFF - k[3:0];
          default: r = lvl[15:0] ^ k[7:0];
        endcase
        case (skip_mode)
          0: sk = 1'b1;
          1, 2, 3, 4: sk = 1'b0;
          5, 6, 7: sk = ($urandom_range(0, 7) == 0);
          default: sk = $urandom_range(0, 1);
        endcase
        push_sample(r, sk, (pos == 0) ? ($urandom_range(0, 7) == 0)
                                      : $urandom_range(0, 1));
        pos++;
        left--;
      end
      if (pos >= len) pos = 0;
    end
  endtask

  int unsigned phase_shift [12] = '{3, 3, 2, 1, 3, 0, 2, 2, 3, 1, 3, 2};

  initial begin
    int unsigned p, n;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: 16-bin frames. First frame refills (none seen yet), with
    // extremes and a skipped mix; second frame forces fill and skips every
    // bin, so min/max stay at their start values and mid is held.
    write_shift(3);
    push_sample(16'h0000, 1'b0, 1'b0);
    push_sample(16'hFFFF, 1'b0, 1'b1);
    push_sample(16'h0000, 1'b1, 1'b0);
    push_sample(16'hFFFF, 1'b1, 1'b1);
    push_sample(16'h0001, 1'b0, 1'b0);
    push_sample(16'hFFFE, 1'b0, 1'b0);
    push_sample(16'h8000, 1'b0, 1'b0);
    push_sample(16'h7FFF, 1'b0, 1'b0);
    for (p = 8; p < 16; p++) push_sample($urandom, p[0], 1'b0);
    push_sample(16'hFFFF, 1'b1, 1'b1);
    for (p = 1; p < 16; p++) push_sample($urandom, 1'b1, 1'b0);
    drain();

    // Random phases over every bin count; phases often end mid-frame so
    // the new shift lands at the next frame start.
    for (p = 0; p < 12; p++) begin
      write_shift(phase_shift[p]);
      n = (phase_shift[p] == 0) ? 2 * BASE_BINS + $urandom_range(1, 40)
                                : $urandom_range(60, 100);
      queue_frames(n, phase_shift[p]);
      drain();
    end

    repeat (60) @(posedge clk);
    if (errors == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

### spectrum_frame_moving_average_core.f
rtl/sfma_pkg.sv
rtl/sfma_div.sv
rtl/spectrum_frame_moving_average_core.sv
rtl/sfma_check.sv
tb/tb.sv
